[rtl/partition_fit_allocator_assert.svh]
// assertion macros shared by the checker of the partition fit allocator
// depends on a clk and an active-low rst_n in the scope that uses them
`ifndef PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pfa_pkg.sv]
// shared types and constants of the partition fit allocator
// no dependencies; imported by every module and interface of the block
package pfa_pkg;

    localparam int NUM_BLOCKS_DEF = 64;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int MODE_W       = 1;
    localparam int INDEX_W      = 6;
    localparam int FIELD_SIZE_W = 16;
    localparam int POLICY_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_POLICY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_COUNT  = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_issue;
        logic commit_load;
        logic commit_alloc;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_is_alloc;
        logic limit_zero;
        logic scan_last;
    } dp_status_t;

endpackage

[rtl/pfa_if.sv]
// channel interfaces of the partition fit allocator: request, response, config
// depends on pfa_pkg for the field widths
interface alloc_req_if import pfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [INDEX_W-1:0]      partition_index;
    logic [FIELD_SIZE_W-1:0] size_value;

    modport source (output valid, mode, partition_index, size_value, input ready);
    modport sink   (input valid, mode, partition_index, size_value, output ready);
endinterface

interface alloc_rsp_if import pfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [INDEX_W-1:0]      chosen_partition;
    logic [FIELD_SIZE_W-1:0] remaining_after;

    modport source (output valid, granted, chosen_partition, remaining_after, input ready);
    modport sink   (input valid, granted, chosen_partition, remaining_after, output ready);
endinterface

interface alloc_cfg_if import pfa_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pfa_datapath.sv]
// datapath: config registers, free size memory, scan compare and result register
// depends on pfa_pkg; driven by pfa_controller through ctl_cmd_t
module pfa_datapath import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_cmd_t                cmd,
    output dp_status_t              status,
    input  logic [MODE_W-1:0]       in_mode,
    input  logic [INDEX_W-1:0]      in_index,
    input  logic [FIELD_SIZE_W-1:0] in_size,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    res_granted,
    output logic [INDEX_W-1:0]      res_partition,
    output logic [FIELD_SIZE_W-1:0] res_remaining
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [POLICY_W-1:0]   policy_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]      limit;

    logic [INDEX_W-1:0]    idx_reg;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic [CNT_W-1:0]      addr_reg;
    logic                  rd_pend_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  found_reg;
    logic [SIZE_WIDTH-1:0] best_reg;
    logic [IDX_W-1:0]      pick_reg;

    logic                  res_granted_reg;
    logic [INDEX_W-1:0]    res_partition_reg;
    logic [FIELD_SIZE_W-1:0] res_remaining_reg;

    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;

    logic                  fits;
    logic                  take;
    logic                  idx_ok;
    logic [SIZE_WIDTH-1:0] left_after;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_IDX_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // searched range clipped to the table
    always_comb
    begin
        if (32'(count_reg) > 32'(NUM_BLOCKS))
            limit = CNT_W'(NUM_BLOCKS);
        else
            limit = CNT_W'(count_reg);
    end

    assign status.req_is_alloc = (in_mode == MODE_ALLOC);
    assign status.limit_zero   = (limit == '0);
    assign status.scan_last    = ((addr_reg + CNT_W'(1)) == limit);

    assign fits       = (rd_data_reg >= size_reg);
    assign take       = rd_pend_reg && fits &&
                        (!found_reg ||
                         ((policy_reg == POLICY_BEST) && (rd_data_reg < best_reg)) ||
                         ((policy_reg == POLICY_WORST) && (rd_data_reg > best_reg)));
    assign idx_ok     = (32'(idx_reg) < 32'(NUM_BLOCKS));
    assign left_after = best_reg - size_reg;

    // item capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= in_index;
            size_reg <= SIZE_WIDTH'(in_size);
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
            rd_idx_reg  <= addr_reg[IDX_W-1:0];
        end
        if (take)
        begin
            best_reg <= rd_data_reg;
            pick_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.capture)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_issue)
                    addr_reg <= addr_reg + CNT_W'(1);
                if (take)
                    found_reg <= 1'b1;
            end
        end
    end

    // single write port shared by loads and allocations
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pick_reg;
        wr_data = left_after;
        if (cmd.commit_load)
        begin
            wr_en   = idx_ok;
            wr_addr = IDX_W'(idx_reg);
            wr_data = size_reg;
        end
        else if (cmd.commit_alloc)
        begin
            wr_en = found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit_load)
        begin
            res_granted_reg   <= idx_ok;
            res_partition_reg <= idx_ok ? idx_reg : '0;
            res_remaining_reg <= idx_ok ? FIELD_SIZE_W'(size_reg) : '0;
        end
        else if (cmd.commit_alloc)
        begin
            res_granted_reg   <= found_reg;
            res_partition_reg <= found_reg ? INDEX_W'(pick_reg) : '0;
            res_remaining_reg <= found_reg ? FIELD_SIZE_W'(left_after) : '0;
        end
    end

    assign res_granted   = res_granted_reg;
    assign res_partition = res_partition_reg;
    assign res_remaining = res_remaining_reg;

endmodule

[rtl/pfa_controller.sv]
// controller state machine of the partition fit allocator
// depends on pfa_pkg; steers pfa_datapath through ctl_cmd_t
module pfa_controller import pfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;
    logic   commit;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!status.req_is_alloc)
                        state_next = S_LOAD;
                    else if (status.limit_zero)
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.commit_load = 1'b1;
                    commit          = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (status.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last read is compared in this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit_alloc = 1'b1;
                    commit           = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/partition_fit_allocator.sv]
// partition fit allocator top level: channel wiring, controller and datapath
// depends on pfa_pkg, pfa_if, pfa_controller and pfa_datapath
//
// keeps the free size of up to NUM_BLOCKS partitions in an internal memory of
// SIZE_WIDTH-bit words. a load transaction (mode 0) writes one partition's size
// and answers with that partition and size, or a refusal if the index lies
// beyond the table. an allocate transaction (mode 1) scans partitions 0 .. N-1
// upward, where N is partition_count clipped to NUM_BLOCKS, one memory read per
// cycle through the single read port, and picks by fit_policy: 0 first fit,
// 1 best fit, 2 worst fit (code 3 acts as first fit); ties go to the lowest
// index. the chosen partition is reduced by the request and the response
// carries granted, chosen_partition and remaining_after; a refusal carries
// zeros and changes nothing. one transaction is in work at a time. the
// response sits in an output register, and the next request is taken while an
// earlier response still waits there. the memory is not cleared at reset:
// entries inside the searched range must be loaded before they are searched.
// configuration (index 0 fit_policy, index 1 partition_count, other indexes
// ignored) is always ready and must only be written while the block is idle
module partition_fit_allocator import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    alloc_req_if.sink   req,
    alloc_rsp_if.source rsp,
    alloc_cfg_if.sink   cfg
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       ctl_req_ready;
    logic       ctl_rsp_valid;
    logic       cfg_we;

    // config registers take a write in any cycle
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    // sequencing: idle, load commit, scan, drain of the last read, commit
    pfa_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctl_req_ready),
        .rsp_valid (ctl_rsp_valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, compare and result payload
    pfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_mode       (req.mode),
        .in_index      (req.partition_index),
        .in_size       (req.size_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res_granted   (rsp.granted),
        .res_partition (rsp.chosen_partition),
        .res_remaining (rsp.remaining_after)
    );

    assign req.ready = ctl_req_ready;
    assign rsp.valid = ctl_rsp_valid;

endmodule

[rtl/pfa_checker.sv]
// port-level checks of the partition fit allocator, bound to the top level
// depends on pfa_pkg and partition_fit_allocator_assert.svh
`include "partition_fit_allocator_assert.svh"

module pfa_checker import pfa_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    rsp_granted,
    input logic [INDEX_W-1:0]      rsp_chosen_partition,
    input logic [FIELD_SIZE_W-1:0] rsp_remaining_after
);

    // a refusal carries zero partition and zero size
    `PFA_ASSERT_NOW(a_refusal_zero, rsp_valid && !rsp_granted, (rsp_chosen_partition == '0) && (rsp_remaining_after == '0), "refused response with non-zero fields")

    // one transaction in work: request side closes after an accept
    `PFA_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "request taken while another is in work")

    // the request side only reopens once the previous response is registered
    `PFA_ASSERT_NOW(a_reopen_with_rsp, $rose(req_ready), rsp_valid, "request side reopened without a response")

    // a stalled response holds
    `PFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_chosen_partition) && $stable(rsp_remaining_after), "response changed while stalled")

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_granted          (rsp.granted),
    .rsp_chosen_partition (rsp.chosen_partition),
    .rsp_remaining_after  (rsp.remaining_after)
);

[test/pfa_fit_checker.sv]
// response checker for the partition fit allocator: mirrors the free size table,
// predicts every response and compares it with what the block returns
// depends on pfa_pkg and the channel interfaces of pfa_if
module pfa_fit_checker import pfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    alloc_req_if req,
    alloc_rsp_if rsp,
    alloc_cfg_if cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic                    granted;
        logic [INDEX_W-1:0]      chosen;
        logic [FIELD_SIZE_W-1:0] remaining;
    } fit_outcome_t;

    logic [FIELD_SIZE_W-1:0] free_left [NUM_BLOCKS_DEF];
    logic [POLICY_W-1:0]     policy_now;
    logic [COUNT_W-1:0]      count_now;
    fit_outcome_t            awaited_q [$];

    // applies one request transaction to the mirrored table and returns its outcome
    function automatic fit_outcome_t load_or_place(input logic [MODE_W-1:0] mode,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [FIELD_SIZE_W-1:0] size);
        fit_outcome_t outcome;
        int           span;
        int           pick;
        int           j;
        bit           found;
        outcome = '0;
        pick    = 0;
        found   = 1'b0;
        if (mode == MODE_LOAD) begin
            free_left[idx]    = size;
            outcome.granted   = 1'b1;
            outcome.chosen    = idx;
            outcome.remaining = size;
            return outcome;
        end
        span = (int'(count_now) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(count_now);
        for (j = 0; j < span; j++) begin
            if (free_left[j] >= size) begin
                if (!found) begin
                    pick  = j;
                    found = 1'b1;
                    // spare policy code behaves as first fit
                    if (policy_now != POLICY_BEST && policy_now != POLICY_WORST)
                        break;
                end
                else if (policy_now == POLICY_BEST && free_left[j] < free_left[pick])
                    pick = j;
                else if (policy_now == POLICY_WORST && free_left[j] > free_left[pick])
                    pick = j;
            end
        end
        if (found) begin
            free_left[pick]   = free_left[pick] - size;
            outcome.granted   = 1'b1;
            outcome.chosen    = INDEX_W'(pick);
            outcome.remaining = free_left[pick];
        end
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        fit_outcome_t want;
        bit           bad;
        int           j;
        bad = 1'b0;
        if (!rst_n) begin
            for (j = 0; j < NUM_BLOCKS_DEF; j++)
                free_left[j] = '0;
            policy_now = POLICY_FIRST;
            count_now  = '0;
            awaited_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_IDX_POLICY)
                    policy_now = cfg.data[POLICY_W-1:0];
                else if (cfg.index == CFG_IDX_COUNT)
                    count_now = cfg.data[COUNT_W-1:0];
            end
            // responses first, so one arriving with nothing queued is caught
            if (rsp.valid && rsp.ready) begin
                if (awaited_q.size() == 0) begin
                    $error("response with no transaction awaiting it: granted %0d, partition %0d, remaining %0d",
                           rsp.granted, rsp.chosen_partition, rsp.remaining_after);
                    bad = 1'b1;
                end
                else begin
                    want = awaited_q.pop_front();
                    if (rsp.granted !== want.granted) begin
                        $error("granted: expected %0d, actual %0d", want.granted, rsp.granted);
                        bad = 1'b1;
                    end
                    if (rsp.chosen_partition !== want.chosen) begin
                        $error("chosen_partition: expected %0d, actual %0d",
                               want.chosen, rsp.chosen_partition);
                        bad = 1'b1;
                    end
                    if (rsp.remaining_after !== want.remaining) begin
                        $error("remaining_after: expected %0d, actual %0d",
                               want.remaining, rsp.remaining_after);
                        bad = 1'b1;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_q.push_back(load_or_place(req.mode, req.partition_index, req.size_value));
            if (bad)
                mismatches <= mismatches + 1;
            outstanding <= awaited_q.size();
        end
    end

endmodule

[test/tb_top.sv]
// testbench top for the partition fit allocator: clock, reset, stimulus and verdict
// depends on pfa_pkg, pfa_if, partition_fit_allocator and pfa_fit_checker
module tb_top;
    import pfa_pkg::*;

    // spare policy code, expected to act as first fit
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;
    // partition counts beyond the table are clipped by the block
    localparam logic [COUNT_W-1:0]  COUNT_OVER   = 7'd127;

    // cycles with no transaction on any channel before the run is abandoned;
    // the slowest legal wait is a full 64-entry scan plus both stalls
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last response
    localparam int TAIL_CYCLES    = 80;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 106;

    // policy and partition count for each random phase, extremes included
    localparam logic [POLICY_W-1:0] PLAN_POLICY [PHASES] = '{
        POLICY_BEST, POLICY_FIRST, POLICY_WORST, POLICY_SPARE, POLICY_BEST, POLICY_WORST,
        POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_SPARE, POLICY_BEST
    };
    localparam logic [COUNT_W-1:0] PLAN_COUNT [PHASES] = '{
        7'd64, 7'd8, 7'd64, 7'd16, 7'd1, COUNT_OVER,
        7'd64, 7'd33, 7'd2, 7'd0, 7'd64, COUNT_OVER
    };

    logic clk;
    logic rst_n;

    alloc_req_if req ();
    alloc_rsp_if rsp ();
    alloc_cfg_if cfg ();

    int mismatches;
    int outstanding;

    // stimulus bookkeeping
    bit          loaded [NUM_BLOCKS_DEF];
    int          span_now;
    bit          calm;
    int unsigned rsp_hold;
    bit          rsp_took;
    int          idle_run;
    int          n_loads;
    int          n_allocs;
    int          n_settings;

    partition_fit_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    pfa_fit_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock: period 20
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // response side back-pressure: after each response transaction a fresh random
    // stall is drawn, none while the run is in a calm stretch
    always @(posedge clk)
        rsp_took <= rsp.valid && rsp.ready;

    always @(negedge clk) begin
        if (rsp_took)
            rsp_hold = calm ? 0 : $urandom_range(0, 10);
        if (rsp_hold > 0) begin
            rsp.ready <= 1'b0;
            rsp_hold   = rsp_hold - 1;
        end
        else
            rsp.ready <= 1'b1;
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // sizes spread over zero, full scale, small, medium and the whole range
    function automatic logic [FIELD_SIZE_W-1:0] draw_size();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3, 4: return FIELD_SIZE_W'($urandom_range(1, 64));
            5, 6:    return FIELD_SIZE_W'($urandom_range(1, 4096));
            default: return FIELD_SIZE_W'($urandom());
        endcase
    endfunction

    // one request transaction, preceded by a random gap unless calm;
    // returns just after the accepting edge so valid is never dropped and raised
    // in the same step
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [INDEX_W-1:0] idx,
                             input logic [FIELD_SIZE_W-1:0] size);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid           <= 1'b1;
        req.mode            <= mode;
        req.partition_index <= idx;
        req.size_value      <= size;
        do
            @(posedge clk);
        while (!req.ready);
        if (mode == MODE_LOAD) begin
            loaded[idx] = 1'b1;
            n_loads++;
        end
        else
            n_allocs++;
    endtask

    // holds the request side quiet until every response has come back
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // both registers written back to back, only once the block is idle
    task automatic apply_settings(input logic [POLICY_W-1:0] pol,
                                  input logic [COUNT_W-1:0] cnt);
        drain();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_IDX_POLICY;
        cfg.data  <= CFG_DATA_W'(pol);
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.index <= CFG_IDX_COUNT;
        cfg.data  <= CFG_DATA_W'(cnt);
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        span_now = (int'(cnt) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(cnt);
        n_settings++;
    endtask

    // hand-picked transactions: count zero, zero and full-scale sizes, ties under
    // best and worst fit, loads outside the searched range, the spare policy code
    task automatic run_directed();
        // nothing searched yet, so this is refused
        send_item(MODE_ALLOC, 6'd0, 16'd5);
        send_item(MODE_LOAD, 6'd0, 16'hFFFF);
        send_item(MODE_LOAD, 6'd1, 16'd100);
        send_item(MODE_LOAD, 6'd2, 16'd40);
        send_item(MODE_LOAD, 6'd3, 16'd100);
        // loads beyond the searched range are still stored
        send_item(MODE_LOAD, 6'd63, 16'h5A5A);
        send_item(MODE_LOAD, 6'd62, 16'd0);

        apply_settings(POLICY_FIRST, 7'd4);
        // zero request leaves the chosen partition untouched
        send_item(MODE_ALLOC, 6'd63, 16'd0);
        send_item(MODE_ALLOC, 6'd0, 16'hFFFF);
        send_item(MODE_ALLOC, 6'd21, 16'd30);
        send_item(MODE_ALLOC, 6'd42, 16'd200);

        apply_settings(POLICY_BEST, 7'd4);
        send_item(MODE_ALLOC, 6'd0, 16'd35);
        // two partitions of equal size, lowest index should win
        send_item(MODE_LOAD, 6'd1, 16'd100);
        send_item(MODE_ALLOC, 6'd0, 16'd100);

        apply_settings(POLICY_WORST, 7'd4);
        send_item(MODE_LOAD, 6'd2, 16'd100);
        send_item(MODE_ALLOC, 6'd0, 16'd10);
        send_item(MODE_ALLOC, 6'd0, 16'd1);

        apply_settings(POLICY_SPARE, 7'd4);
        send_item(MODE_ALLOC, 6'd0, 16'd1);
        send_item(MODE_ALLOC, 6'd0, 16'd0);
        send_item(MODE_ALLOC, 6'd0, 16'hFFFF);
    endtask

    // random phase: partitions in the searched range that were never loaded get
    // loaded first, then a mix of loads and allocations with random content
    task automatic run_phase(input logic [POLICY_W-1:0] pol,
                             input logic [COUNT_W-1:0] cnt);
        int                 k;
        int                 j;
        int                 hole;
        logic [INDEX_W-1:0] idx;
        apply_settings(pol, cnt);
        calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < PHASE_ITEMS; k++) begin
            hole = -1;
            for (j = span_now - 1; j >= 0; j--)
                if (!loaded[j])
                    hole = j;
            if (hole >= 0)
                send_item(MODE_LOAD, INDEX_W'(hole), draw_size());
            else if ($urandom_range(0, 99) < 35) begin
                if (span_now > 0 && $urandom_range(0, 1) == 1)
                    idx = INDEX_W'($urandom_range(0, span_now - 1));
                else
                    idx = INDEX_W'($urandom_range(0, NUM_BLOCKS_DEF - 1));
                send_item(MODE_LOAD, idx, draw_size());
            end
            else
                // index is ignored by allocations, so it is left random
                send_item(MODE_ALLOC, INDEX_W'($urandom_range(0, NUM_BLOCKS_DEF - 1)),
                          draw_size());
            // now and then let everything come back before carrying on
            if ($urandom_range(0, 49) == 0)
                drain();
            if ($urandom_range(0, 29) == 0)
                calm = !calm;
        end
    endtask

    initial begin
        int p;
        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.mode            = MODE_LOAD;
        req.partition_index = '0;
        req.size_value      = '0;
        rsp.ready           = 1'b0;
        cfg.valid           = 1'b0;
        cfg.index           = CFG_IDX_POLICY;
        cfg.data            = '0;
        rsp_hold            = 0;
        rsp_took            = 1'b0;
        idle_run            = 0;
        calm                = 1'b0;
        span_now            = 0;
        n_loads             = 0;
        n_allocs            = 0;
        n_settings          = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (p = 0; p < PHASES; p++)
            run_phase(PLAN_POLICY[p], PLAN_COUNT[p]);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d allocations under %0d register settings",
                 n_loads, n_allocs, n_settings);
        $display("all four policy codes, counts 0 to 127, zero and full-scale sizes, ties");
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_datapath.sv
rtl/pfa_controller.sv
rtl/partition_fit_allocator.sv
rtl/pfa_checker.sv
test/pfa_fit_checker.sv
test/tb_top.sv
